// ===== sv/iatp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iatp_pkg
// Shared types, character codes and group helpers for the host literal parser.
// ----------------------------------------------------------------------------
package iatp_pkg;

   // Number of 16-bit groups in an IPv6 address
   localparam int GroupCount = 8;

   // Characters with a meaning of their own
   localparam logic [7:0] CharLBracket = 8'h5B;
   localparam logic [7:0] CharRBracket = 8'h5D;
   localparam logic [7:0] CharColon    = 8'h3A;
   localparam logic [7:0] CharDot      = 8'h2E;

   // Result kind codes
   localparam logic [1:0] KindNone = 2'd0;
   localparam logic [1:0] KindIpv4 = 2'd1;
   localparam logic [1:0] KindIpv6 = 2'd2;

   typedef enum logic [1:0] {
      FormStart = 2'd0,
      FormV4    = 2'd1,
      FormV6    = 2'd2,
      FormNone  = 2'd3
   } form_type;

   typedef enum logic [2:0] {
      PhHead      = 3'd0,
      PhHeadColon = 3'd1,
      PhTail      = 3'd2,
      PhTailColon = 3'd3,
      PhAfter     = 3'd4,
      PhSkip      = 3'd5,
      PhPort      = 3'd6,
      PhField     = 3'd7
   } phase_type;

   typedef logic [0:GroupCount-1][15:0] group_array_type;

   // Full parser state; tail groups are kept right-aligned (newest at the end)
   typedef struct packed {
      form_type        form;
      phase_type       phase;
      logic [3:0]      fidx;
      logic [31:0]     facc;
      logic [31:0]     ipv4;
      group_array_type head;
      group_array_type tail;
      logic [3:0]      tcnt;
      logic [15:0]     port;
      logic            gdig;
      logic            dend;
   } parse_state_type;

   function automatic parse_state_type reset_state();
      parse_state_type r;
      r.form  = FormStart;
      r.phase = PhHead;
      r.fidx  = '0;
      r.facc  = '0;
      r.ipv4  = '0;
      r.head  = '0;
      r.tail  = '0;
      r.tcnt  = '0;
      r.port  = '0;
      r.gdig  = 1'b0;
      r.dend  = 1'b0;
      return r;
   endfunction

   // Close the open hex group into the head list or the tail list
   function automatic parse_state_type close_group(input parse_state_type s,
                                                   input logic in_head);
      parse_state_type r;
      r = s;
      if (s.gdig) begin
         if (in_head) begin
            if (!s.fidx[3]) begin
               r.head[s.fidx[2:0]] = s.facc[15:0];
               r.fidx = s.fidx + 4'd1;
            end
         end else if (!s.tcnt[3]) begin
            r.tail = {s.tail[1:GroupCount-1], s.facc[15:0]};
            r.tcnt = s.tcnt + 4'd1;
         end
      end
      r.gdig = 1'b0;
      r.facc = '0;
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/iatp_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iatp_parse
// Parser state register and the per-character update. Presents the updated
// state so the final beat can be assembled in the same cycle.
// ----------------------------------------------------------------------------
module iatp_parse (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step_en,
   input  wire logic [7:0]               char_in,
   input  wire logic                     last_char,
   output iatp_pkg::parse_state_type     state_next
);

   iatp_pkg::parse_state_type state_ff;
   iatp_pkg::parse_state_type state_in;

   logic       dec_ok;
   logic [3:0] dec_val;
   logic       hex_ok;
   logic [3:0] hex_val;
   logic [31:0] facc_x10;
   logic [15:0] port_x10;
   logic        v4_sep;

   // Switch to the port (or the skipped character before it)
   function automatic iatp_pkg::parse_state_type after_check(
      input iatp_pkg::parse_state_type s, input logic [7:0] c);
      iatp_pkg::parse_state_type r;
      r = s;
      if (c == iatp_pkg::CharRBracket) begin
         r.phase = iatp_pkg::PhSkip;
      end else begin
         r.phase = iatp_pkg::PhPort;
         r.port  = '0;
         r.dend  = 1'b0;
      end
      return r;
   endfunction

   // One character inside the head or tail group list
   function automatic iatp_pkg::parse_state_type group_char(
      input iatp_pkg::parse_state_type s, input logic [7:0] c,
      input logic h_ok, input logic [3:0] h_val, input logic in_head);
      iatp_pkg::parse_state_type r;
      r = s;
      if (h_ok) begin
         r.facc  = {16'd0, s.facc[11:0], h_val};
         r.gdig  = 1'b1;
         r.phase = in_head ? iatp_pkg::PhHead : iatp_pkg::PhTail;
      end else if (c == iatp_pkg::CharColon) begin
         r = iatp_pkg::close_group(s, in_head);
         r.phase = in_head ? iatp_pkg::PhHeadColon : iatp_pkg::PhTailColon;
      end else begin
         r = after_check(iatp_pkg::close_group(s, in_head), c);
      end
      return r;
   endfunction

   // Decode the character
   always_comb begin
      dec_ok  = (char_in >= 8'h30) && (char_in <= 8'h39);
      dec_val = char_in[3:0];
      hex_ok  = 1'b1;
      hex_val = char_in[3:0];
      if (dec_ok) begin
         hex_val = char_in[3:0];
      end else if (((char_in >= 8'h41) && (char_in <= 8'h46)) ||
                   ((char_in >= 8'h61) && (char_in <= 8'h66))) begin
         hex_val = char_in[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign facc_x10 = {state_ff.facc[28:0], 3'b000} + {state_ff.facc[30:0], 1'b0};
   assign port_x10 = {state_ff.port[12:0], 3'b000} + {state_ff.port[14:0], 1'b0};
   assign v4_sep   = (state_ff.fidx < 4'd3) ? (char_in == iatp_pkg::CharDot)
                                            : (char_in == iatp_pkg::CharColon);

   // Advance the state by one character
   always_comb begin
      state_in = state_ff;
      case (state_ff.form)
         iatp_pkg::FormStart: begin
            if (char_in == iatp_pkg::CharLBracket) begin
               state_in.form  = iatp_pkg::FormV6;
               state_in.phase = iatp_pkg::PhHead;
            end else if (dec_ok) begin
               state_in.form  = iatp_pkg::FormV4;
               state_in.phase = iatp_pkg::PhField;
               state_in.facc  = {28'd0, dec_val};
            end else begin
               state_in.form = iatp_pkg::FormNone;
            end
         end
         iatp_pkg::FormV4: begin
            if (state_ff.phase == iatp_pkg::PhPort) begin
               if (!state_ff.dend && dec_ok) begin
                  state_in.port = port_x10 + {12'd0, dec_val};
               end else begin
                  state_in.dend = 1'b1;
               end
            end else if (!state_ff.dend && dec_ok) begin
               state_in.facc = facc_x10 + {28'd0, dec_val};
            end else begin
               state_in.dend = 1'b1;
               if (v4_sep) begin
                  state_in.ipv4 = {state_ff.ipv4[23:0], 8'd0} + state_ff.facc;
                  state_in.facc = '0;
                  state_in.dend = 1'b0;
                  if (state_ff.fidx >= 4'd3) begin
                     state_in.fidx  = 4'd4;
                     state_in.phase = iatp_pkg::PhPort;
                     state_in.port  = '0;
                  end else begin
                     state_in.fidx = state_ff.fidx + 4'd1;
                  end
               end
            end
         end
         iatp_pkg::FormV6: begin
            case (state_ff.phase)
               iatp_pkg::PhHead: begin
                  state_in = group_char(state_ff, char_in, hex_ok, hex_val, 1'b1);
               end
               iatp_pkg::PhHeadColon: begin
                  if (char_in == iatp_pkg::CharColon) begin
                     state_in.phase = iatp_pkg::PhTail;
                     state_in.gdig  = 1'b0;
                     state_in.facc  = '0;
                  end else begin
                     state_in = group_char(state_ff, char_in, hex_ok, hex_val, 1'b1);
                  end
               end
               iatp_pkg::PhTail: begin
                  state_in = group_char(state_ff, char_in, hex_ok, hex_val, 1'b0);
               end
               iatp_pkg::PhTailColon: begin
                  if (char_in == iatp_pkg::CharColon) begin
                     state_in.phase = iatp_pkg::PhAfter;
                  end else begin
                     state_in = group_char(state_ff, char_in, hex_ok, hex_val, 1'b0);
                  end
               end
               iatp_pkg::PhAfter: begin
                  state_in = after_check(state_ff, char_in);
               end
               iatp_pkg::PhSkip: begin
                  state_in.phase = iatp_pkg::PhPort;
                  state_in.port  = '0;
                  state_in.dend  = 1'b0;
               end
               default: begin
                  if (!state_ff.dend && dec_ok) begin
                     state_in.port = port_x10 + {12'd0, dec_val};
                  end else begin
                     state_in.dend = 1'b1;
                  end
               end
            endcase
         end
         default: begin
            state_in = state_ff;
         end
      endcase
   end

   assign state_next = state_in;

   // Hold state; return to the start after the final character
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iatp_pkg::reset_state();
      end else if (step_en) begin
         state_ff <= last_char ? iatp_pkg::reset_state() : state_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/iatp_assemble.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iatp_assemble
// Builds the result beat from the state after the final character: closes an
// open group, merges the tail groups over the head, completes IPv4 fields.
// ----------------------------------------------------------------------------
module iatp_assemble (
   input  wire iatp_pkg::parse_state_type state,
   output logic [1:0]                     addr_kind,
   output logic [63:0]                    addr_upper,
   output logic [63:0]                    addr_lower,
   output logic [15:0]                    port_number
);

   iatp_pkg::parse_state_type fin;
   iatp_pkg::group_array_type groups;
   logic                      open_group;
   logic                      open_head;
   logic [31:0]               v4_addr;

   // Close a group still open at the end of the literal
   always_comb begin
      open_head  = (state.phase == iatp_pkg::PhHead) ||
                   (state.phase == iatp_pkg::PhHeadColon);
      open_group = open_head || (state.phase == iatp_pkg::PhTail) ||
                   (state.phase == iatp_pkg::PhTailColon);
      fin = open_group ? iatp_pkg::close_group(state, open_head) : state;
   end

   // Place the tail groups at the end of the address
   always_comb begin
      for (int p = 0; p < iatp_pkg::GroupCount; p++) begin
         groups[p] = ((4'(p) + fin.tcnt) >= 4'(iatp_pkg::GroupCount)) ? fin.tail[p]
                                                                       : fin.head[p];
      end
   end

   // Shift in the IPv4 fields that were never closed
   always_comb begin
      case (state.fidx)
         4'd0:    v4_addr = {state.facc[7:0], 24'd0};
         4'd1:    v4_addr = {state.ipv4[7:0], 24'd0} + {state.facc[15:0], 16'd0};
         4'd2:    v4_addr = {state.ipv4[15:0], 16'd0} + {state.facc[23:0], 8'd0};
         4'd3:    v4_addr = {state.ipv4[23:0], 8'd0} + state.facc;
         default: v4_addr = state.ipv4;
      endcase
   end

   // Select the result by form
   always_comb begin
      addr_kind   = iatp_pkg::KindNone;
      addr_upper  = '0;
      addr_lower  = '0;
      port_number = '0;
      case (state.form)
         iatp_pkg::FormV4: begin
            addr_kind   = iatp_pkg::KindIpv4;
            addr_lower  = {32'd0, v4_addr};
            port_number = (state.phase == iatp_pkg::PhPort) ? state.port : 16'd0;
         end
         iatp_pkg::FormV6: begin
            addr_kind   = iatp_pkg::KindIpv6;
            addr_upper  = groups[0:3];
            addr_lower  = groups[4:7];
            port_number = (state.phase == iatp_pkg::PhPort) ? state.port : 16'd0;
         end
         default: begin
            addr_kind = iatp_pkg::KindNone;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/ip_address_text_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// A final character passes through the input register, then the parse update
//   into the result register, which waits while the output holds an untaken beat.
// Throughput: one character per cycle, but a final character waits while the output holds an untaken beat.
// Reset: synchronous; clears the parse state and both valid flags.
// ----------------------------------------------------------------------------
// ip_address_text_parser
// Parses an IPv4 or bracketed IPv6 host literal with port, one character per
// beat, and returns one result beat at the final character.
// ----------------------------------------------------------------------------
module ip_address_text_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_char_in,
   input  wire logic        req_last_char,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_addr_kind,
   output logic [63:0]      rsp_addr_upper,
   output logic [63:0]      rsp_addr_lower,
   output logic [15:0]      rsp_port_number
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;
   logic       step_en;
   logic       req_fire;

   iatp_pkg::parse_state_type state_next;
   logic [1:0]  res_kind;
   logic [63:0] res_upper;
   logic [63:0] res_lower;
   logic [15:0] res_port;

   // Step on any held character; a final character steps only when the output has room
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_en   = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || step_en;
   assign req_fire  = req_valid && req_ready;

   assign in_valid_in  = req_fire ? 1'b1 : (step_en ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (step_en && in_last_ff) ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_char_ff <= req_char_in;
         in_last_ff <= req_last_char;
      end
   end

   iatp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .char_in    (in_char_ff),
      .last_char  (in_last_ff),
      .state_next (state_next)
   );

   iatp_assemble u_assemble (
      .state       (state_next),
      .addr_kind   (res_kind),
      .addr_upper  (res_upper),
      .addr_lower  (res_lower),
      .port_number (res_port)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && in_last_ff) begin
         rsp_addr_kind   <= res_kind;
         rsp_addr_upper  <= res_upper;
         rsp_addr_lower  <= res_lower;
         rsp_port_number <= res_port;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the host literal parser. Literals are streamed one
// character per beat with random sender gaps and receiver stalls. A parse
// model in the bench predicts each result beat, and the checker compares it
// field by field against the DUT output.
// ----------------------------------------------------------------------------
module tb_top;
   import iatp_pkg::*;

   localparam int ClockHalf   = 6;
   localparam int ResetCycles = 12;
   localparam int QuietLimit  = 2000;
   localparam int DrainCycles = 8;
   localparam int ReportLimit = 10;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] upper;
      logic [63:0] lower;
      logic [15:0] port;
   } host_addr_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_in = 8'd0;
   logic        req_last_char = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_addr_kind;
   logic [63:0] rsp_addr_upper;
   logic [63:0] rsp_addr_lower;
   logic [15:0] rsp_port_number;

   ip_address_text_parser dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .req_last_char   (req_last_char),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_addr_kind   (rsp_addr_kind),
      .rsp_addr_upper  (rsp_addr_upper),
      .rsp_addr_lower  (rsp_addr_lower),
      .rsp_port_number (rsp_port_number)
   );

   always begin
      #ClockHalf clock = 1'b1;
      #ClockHalf clock = 1'b0;
   end

   // Parse model state for the literal in flight
   form_type    lit_form;
   phase_type   lit_phase;
   logic [3:0]  lit_idx;
   logic [31:0] lit_acc;
   logic [31:0] lit_v4;
   logic [15:0] lit_head [8];
   logic [15:0] lit_tail [8];
   logic [3:0]  lit_tcnt;
   logic [15:0] lit_port;
   bit          lit_gdig;
   bit          lit_dend;

   host_addr_t  expected_addrs [$];
   logic [7:0]  host_text [$];
   int unsigned chars_sent = 0;
   int unsigned burst_left = 0;
   int unsigned fail_count = 0;
   int unsigned quiet_cycles = 0;

   function automatic bit is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic int hex_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return c - "0";
      if (c >= "A" && c <= "F") return c - "A" + 10;
      if (c >= "a" && c <= "f") return c - "a" + 10;
      return -1;
   endfunction

   function void clear_literal();
      int i;
      lit_form  = FormStart;
      lit_phase = PhHead;
      lit_idx   = '0;
      lit_acc   = '0;
      lit_v4    = '0;
      for (i = 0; i < 8; i++) begin
         lit_head[i] = '0;
         lit_tail[i] = '0;
      end
      lit_tcnt = '0;
      lit_port = '0;
      lit_gdig = 1'b0;
      lit_dend = 1'b0;
   endfunction

   function void start_port();
      lit_phase = PhPort;
      lit_port  = '0;
      lit_dend  = 1'b0;
   endfunction

   // Store the open hex group into head or tail; extra groups are dropped
   function void close_group();
      if (lit_gdig) begin
         if (lit_phase == PhHead || lit_phase == PhHeadColon) begin
            if (lit_idx < 4'd8) begin
               lit_head[lit_idx[2:0]] = lit_acc[15:0];
               lit_idx = lit_idx + 4'd1;
            end
         end else if (lit_tcnt < 4'd8) begin
            lit_tail[lit_tcnt[2:0]] = lit_acc[15:0];
            lit_tcnt = lit_tcnt + 4'd1;
         end
      end
      lit_gdig = 1'b0;
      lit_acc  = '0;
   endfunction

   function void bracket_check(logic [7:0] c);
      if (c == CharRBracket) begin
         lit_phase = PhSkip;
      end else begin
         start_port();
      end
   endfunction

   function void port_digit(logic [7:0] c);
      if (!lit_dend && is_digit(c)) begin
         lit_port = lit_port * 16'd10 + (c - "0");
      end else begin
         lit_dend = 1'b1;
      end
   endfunction

   function void group_step(logic [7:0] c, bit in_head);
      int h;
      h = hex_value(c);
      if (h >= 0) begin
         lit_acc   = ((lit_acc << 4) | h) & 32'hFFFF;
         lit_gdig  = 1'b1;
         lit_phase = in_head ? PhHead : PhTail;
      end else if (c == CharColon) begin
         close_group();
         lit_phase = in_head ? PhHeadColon : PhTailColon;
      end else begin
         close_group();
         bracket_check(c);
      end
   endfunction

   // Decimal fields shift in by eight bits; digits after a non-digit are dropped
   function void v4_step(logic [7:0] c);
      if (lit_phase == PhPort) begin
         port_digit(c);
      end else if (!lit_dend && is_digit(c)) begin
         lit_acc = lit_acc * 32'd10 + (c - "0");
      end else begin
         lit_dend = 1'b1;
         if ((lit_idx < 4'd3 && c == CharDot) || (lit_idx >= 4'd3 && c == CharColon)) begin
            lit_v4   = (lit_v4 << 8) + lit_acc;
            lit_acc  = '0;
            lit_dend = 1'b0;
            lit_idx  = lit_idx + 4'd1;
            if (lit_idx >= 4'd4) begin
               lit_idx = 4'd4;
               start_port();
            end
         end
      end
   endfunction

   function void v6_step(logic [7:0] c);
      case (lit_phase)
         PhHead: begin
            group_step(c, 1'b1);
         end
         PhHeadColon: begin
            if (c == CharColon) begin
               lit_phase = PhTail;
               lit_gdig  = 1'b0;
               lit_acc   = '0;
            end else begin
               group_step(c, 1'b1);
            end
         end
         PhTail: begin
            group_step(c, 1'b0);
         end
         PhTailColon: begin
            if (c == CharColon) begin
               lit_phase = PhAfter;
            end else begin
               group_step(c, 1'b0);
            end
         end
         PhAfter: begin
            bracket_check(c);
         end
         PhSkip: begin
            start_port();
         end
         default: begin
            port_digit(c);
         end
      endcase
   endfunction

   // Advance the model by one character; queue the address at the final one
   function void parse_char(logic [7:0] c, logic last);
      host_addr_t  r;
      logic [31:0] v;
      logic [15:0] g [8];
      int          i;
      int          j;
      case (lit_form)
         FormStart: begin
            if (c == CharLBracket) begin
               lit_form  = FormV6;
               lit_phase = PhHead;
            end else if (is_digit(c)) begin
               lit_form  = FormV4;
               lit_phase = PhField;
               v4_step(c);
            end else begin
               lit_form = FormNone;
            end
         end
         FormV4: begin
            v4_step(c);
         end
         FormV6: begin
            v6_step(c);
         end
         default: begin
         end
      endcase
      if (last) begin
         r = '0;
         if (lit_form == FormV4) begin
            // missing fields read as zero but still shift
            v = lit_v4;
            for (i = lit_idx; i < 4; i++) begin
               v = (v << 8) + ((i == lit_idx) ? lit_acc : 32'd0);
            end
            r.kind  = KindIpv4;
            r.lower = {32'd0, v};
            r.port  = (lit_phase == PhPort) ? lit_port : 16'd0;
         end else if (lit_form == FormV6) begin
            if (lit_phase <= PhTailColon) begin
               close_group();
            end
            for (j = 0; j < 8; j++) begin
               g[j] = lit_head[j];
            end
            // tail groups land at the end and win over head groups
            for (j = 0; j < int'(lit_tcnt); j++) begin
               g[8 - int'(lit_tcnt) + j] = lit_tail[j];
            end
            r.kind  = KindIpv6;
            r.upper = {g[0], g[1], g[2], g[3]};
            r.lower = {g[4], g[5], g[6], g[7]};
            r.port  = (lit_phase == PhPort) ? lit_port : 16'd0;
         end
         expected_addrs.push_back(r);
         clear_literal();
      end
   endfunction

   function void flag_error(string what, logic [63:0] want, logic [63:0] got);
      fail_count++;
      if (fail_count <= ReportLimit) begin
         $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
      end
   endfunction

   // Predict on every accepted character, check every accepted result beat
   always @(posedge clock) begin : monitor
      host_addr_t want;
      if (reset) begin
         clear_literal();
         quiet_cycles = 0;
      end else begin
         if (req_valid && req_ready) begin
            parse_char(req_char_in, req_last_char);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_addrs.size() == 0) begin
               flag_error("result beat with no literal pending, kind", 64'd0,
                          {62'd0, rsp_addr_kind});
            end else begin
               want = expected_addrs.pop_front();
               if (rsp_addr_kind !== want.kind)
                  flag_error("addr_kind", {62'd0, want.kind}, {62'd0, rsp_addr_kind});
               if (rsp_addr_upper !== want.upper)
                  flag_error("addr_upper", want.upper, rsp_addr_upper);
               if (rsp_addr_lower !== want.lower)
                  flag_error("addr_lower", want.lower, rsp_addr_lower);
               if (rsp_port_number !== want.port)
                  flag_error("port_number", {48'd0, want.port}, {48'd0, rsp_port_number});
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
   end

   // Receiver stalls on a rotating mask that is re-picked now and then
   logic [15:0] ready_mask = 16'hFFFF;
   int unsigned mask_age = 0;

   always @(negedge clock) begin
      if (mask_age == 0) begin
         mask_age = $urandom_range(20, 120);
         case ($urandom_range(0, 3))
            0:       ready_mask = 16'hFFFF;
            1:       ready_mask = 16'($urandom);
            2:       ready_mask = 16'h00FF;
            default: ready_mask = 16'($urandom) | 16'($urandom);
         endcase
      end else begin
         mask_age--;
         ready_mask = {ready_mask[0], ready_mask[15:1]};
      end
      rsp_ready <= ready_mask[0];
   end

   // Send one character beat; drop valid between bursts
   task automatic send_char(input logic [7:0] c, input logic last);
      req_char_in   <= c;
      req_last_char <= last;
      req_valid     <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 12);
      end else begin
         burst_left--;
      end
   endtask

   task automatic send_text();
      int i;
      for (i = 0; i < host_text.size(); i++) begin
         send_char(host_text[i], i == host_text.size() - 1);
      end
      chars_sent += host_text.size();
      host_text.delete();
   endtask

   function automatic void put_str(string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         host_text.push_back(s[i]);
      end
   endfunction

   function automatic void put_dec(longint unsigned v);
      put_str($sformatf("%0d", v));
   endfunction

   function automatic logic [7:0] junk_char();
      string pool = "xZ/ -#@g";
      return pool[$urandom_range(0, pool.len() - 1)];
   endfunction

   // Hex group of random digits in mixed case; five or six digits wrap
   function automatic void put_group();
      int          k;
      int          n;
      logic [3:0]  nib;
      logic [7:0]  ch;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
      for (k = 0; k < n; k++) begin
         nib = 4'($urandom_range(0, 15));
         if (nib < 4'd10) begin
            ch = "0" + nib;
         end else begin
            ch = ($urandom_range(0, 1) ? "a" : "A") + nib - 4'd10;
         end
         host_text.push_back(ch);
      end
   endfunction

   // Port digits: in range, wrapping, or cut short by a stray character
   function automatic void put_port();
      case ($urandom_range(0, 7))
         0: put_dec($urandom_range(65536, 999999));
         1: begin
            put_dec($urandom_range(0, 65535));
            host_text.push_back(junk_char());
            put_dec($urandom_range(0, 99));
         end
         2: put_dec($urandom_range(0, 9));
         default: put_dec($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic void maybe_truncate();
      int n;
      if ($urandom_range(0, 5) == 0) begin
         n = $urandom_range(1, host_text.size());
         while (host_text.size() > n) void'(host_text.pop_back());
      end
   endfunction

   function automatic void build_ipv4();
      int f;
      int sel;
      for (f = 0; f < 4; f++) begin
         sel = $urandom_range(0, 9);
         if (f > 0 && sel == 0) begin
            // empty field
         end else if (sel <= 6) begin
            put_dec($urandom_range(0, 255));
         end else if (sel == 7) begin
            put_dec($urandom_range(256, 99999));
         end else if (sel == 8) begin
            put_dec({$urandom, $urandom});
         end else begin
            put_dec($urandom_range(0, 255));
            host_text.push_back(junk_char());
            put_dec($urandom_range(0, 99));
         end
         if (f < 3) begin
            // a colon before the fourth field is skipped over
            if ($urandom_range(0, 11) == 0) put_str(":7");
            put_str(".");
         end else if ($urandom_range(0, 5) != 0) begin
            if ($urandom_range(0, 11) == 0) put_str(".3");
            put_str(":");
            put_port();
         end
      end
      maybe_truncate();
   endfunction

   function automatic void build_ipv6();
      int heads;
      int tails;
      int i;
      put_str("[");
      heads = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 8);
      for (i = 0; i < heads; i++) begin
         if (i > 0) put_str(":");
         put_group();
      end
      if ($urandom_range(0, 3) != 0) begin
         put_str("::");
         tails = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 7);
         for (i = 0; i < tails; i++) begin
            if (i > 0) put_str(":");
            put_group();
         end
         // a second compression closes the tail list
         if ($urandom_range(0, 9) == 0) begin
            put_str("::");
            if ($urandom_range(0, 1)) put_group();
         end
      end
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: begin
            put_str("]:");
            put_port();
         end
         6: begin
            put_str("]");
            host_text.push_back(8'($urandom_range(0, 255)));
            put_port();
         end
         7: put_str("]");
         8: begin
            host_text.push_back(junk_char());
            put_port();
         end
         default: begin
         end
      endcase
      maybe_truncate();
   endfunction

   function automatic void corrupt_text();
      repeat ($urandom_range(1, 3)) begin
         host_text[$urandom_range(0, host_text.size() - 1)] = 8'($urandom_range(0, 255));
      end
   endfunction

   // Byte extremes, single-character literals, a short host name and the widest IPv4 literal
   task automatic test_directed_extremes();
      host_text.push_back(8'h00);
      send_text();
      host_text.push_back(8'hFF);
      send_text();
      put_str("[");
      send_text();
      put_str("9");
      send_text();
      put_str("h.x");
      send_text();
      put_str("255.255.255.255:65535");
      send_text();
   endtask

   task automatic test_ipv4_literals(input int unsigned budget);
      int unsigned stop_at;
      stop_at = chars_sent + budget;
      while (chars_sent < stop_at) begin
         build_ipv4();
         send_text();
      end
   endtask

   task automatic test_ipv6_literals(input int unsigned budget);
      int unsigned stop_at;
      stop_at = chars_sent + budget;
      while (chars_sent < stop_at) begin
         build_ipv6();
         send_text();
      end
   endtask

   // Raw noise, damaged literals and host names that parse to kind none
   task automatic test_malformed_literals(input int unsigned budget);
      int unsigned stop_at;
      stop_at = chars_sent + budget;
      while (chars_sent < stop_at) begin
         case ($urandom_range(0, 3))
            0: begin
               repeat ($urandom_range(1, 12)) host_text.push_back(8'($urandom_range(0, 255)));
            end
            1: begin
               build_ipv4();
               corrupt_text();
            end
            2: begin
               build_ipv6();
               corrupt_text();
            end
            default: begin
               repeat ($urandom_range(1, 10))
                  host_text.push_back(8'("a" + $urandom_range(0, 25)));
               put_str(":");
               put_port();
            end
         endcase
         send_text();
      end
   endtask

   initial begin
      repeat (ResetCycles) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed_extremes();
      test_ipv4_literals(380);
      test_ipv6_literals(560);
      test_malformed_literals(200);
      req_valid <= 1'b0;
      while (expected_addrs.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && expected_addrs.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Stop a hung run once nothing has moved for too long
   initial begin
      wait (quiet_cycles >= QuietLimit);
      $display("Simulation FAILED");
      $finish;
   end

endmodule
